[rtl/core/gdds_pkg.sv]
package gdds_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;

	// packed date fields and the byte-filled result payload
	localparam int unsigned DATE_W   = DAY_W + MONTH_W + YEAR_W;
	localparam int unsigned M_DATA_W = ((DATE_W + 7) / 8) * 8;

	localparam logic [DAY_W-1:0]   DAY_FIRST    = DAY_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_FIRST  = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_LAST   = MONTH_W'(12);
	localparam logic [YEAR_W-1:0]  YEAR_MIN     = YEAR_W'(1);
	localparam logic [YEAR_W-1:0]  YEAR_MAX     = YEAR_W'(9999);
	localparam logic [YEAR_W-1:0]  YEAR_DEFAULT = YEAR_W'(2023);

	// ceil(2^17 / 25); low 17 bits of year * this are tiny only for multiples of 25
	localparam int unsigned RECIP25_W = 13;
	localparam logic [RECIP25_W-1:0] RECIP25 = RECIP25_W'(5243);
	localparam int unsigned PROD25_W = YEAR_W + RECIP25_W;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_SHIFT = 1'b1
	} op_t;

	typedef struct packed {
		logic load;     // take the load fields, validate
		logic start;    // take the day count, clear flags
		logic step;     // one day forward or back
		logic capture;  // copy date and flags into the output register
	} cmd_t;

	typedef struct packed {
		logic rem_zero;
	} status_t;

	// leap: divisible by 4 and not by 100, or by 400
	function automatic logic is_leap(input logic [YEAR_W-1:0] year);
		logic [PROD25_W-1:0] prod;
		logic                div25;
		prod  = PROD25_W'(year) * PROD25_W'(RECIP25);
		div25 = (prod[16:12] == 5'd0);
		return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (month)
			4'd2: begin
				len = leap ? DAY_W'(29) : DAY_W'(28);
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				len = DAY_W'(30);
			end
			default: begin
				len = DAY_W'(31);
			end
		endcase
		return len;
	endfunction

endpackage

[rtl/core/gregorian_date_day_stepper.sv]
// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+------------------------------------------------
// s_axis   | in  | s_tvalid/s_tready  | tuser: opcode; tdata: day, month, year, count
// m_axis   | out | m_tvalid/m_tready  | tuser: load_rejected, range_clamped;
//          |     |                    | tdata: day, month, year
//
// A load request passes accept and output write; a shift of N days passes accept, the
// stepping loop (one day per cycle), terminal-count check and output write.
// A shift that hits a year bound ends at that step.
// Reset leaves the date at 1/1/2023 with no result pending.
// One request is worked on at a time; a new one is taken while the previous result
// still waits in the output register. A stalled output holds the block before it
// writes the next result.
module gregorian_date_day_stepper #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// low to high: load_day[5], load_month[4], load_year[14], day_count[COUNT_WIDTH], pad
	input  logic [((gdds_pkg::DATE_W + COUNT_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	// opcode (0 load, 1 shift)
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// low to high: day_out[5], month_out[4], year_out[14], pad[1]
	output logic [gdds_pkg::M_DATA_W-1:0] m_tdata,
	// low to high: load_rejected, range_clamped
	output logic [1:0]            m_tuser
);

	localparam int unsigned MON_LO  = gdds_pkg::DAY_W;
	localparam int unsigned YEAR_LO = MON_LO + gdds_pkg::MONTH_W;

	gdds_pkg::cmd_t    cmd;
	gdds_pkg::status_t status;

	logic [gdds_pkg::DAY_W-1:0]   day_out;
	logic [gdds_pkg::MONTH_W-1:0] month_out;
	logic [gdds_pkg::YEAR_W-1:0]  year_out;
	logic                         load_rejected;
	logic                         range_clamped;

	gdds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_op    (s_tuser),
		.req_ready (s_tready),
		.rsp_valid (m_tvalid),
		.rsp_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	gdds_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.load_day      (s_tdata[MON_LO-1:0]),
		.load_month    (s_tdata[YEAR_LO-1:MON_LO]),
		.load_year     (s_tdata[gdds_pkg::DATE_W-1:YEAR_LO]),
		.day_count     (s_tdata[gdds_pkg::DATE_W+COUNT_WIDTH-1:gdds_pkg::DATE_W]),
		.day_out       (day_out),
		.month_out     (month_out),
		.year_out      (year_out),
		.load_rejected (load_rejected),
		.range_clamped (range_clamped)
	);

	// zero fill above the date fields
	assign m_tdata = gdds_pkg::M_DATA_W'({year_out, month_out, day_out});
	assign m_tuser = {range_clamped, load_rejected};

endmodule

[rtl/core/gdds_ctrl.sv]
module gdds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_op,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  gdds_pkg::status_t status,
	output gdds_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_STEP = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   rsp_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_nx    = state_q;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_op == gdds_pkg::OP_LOAD) begin
						cmd.load = 1'b1;
						state_nx = ST_OUT;
					end else begin
						cmd.start = 1'b1;
						state_nx  = ST_STEP;
					end
				end
			end
			ST_STEP: begin
				if (status.rem_zero) begin
					state_nx = ST_OUT;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.capture = 1'b1;
					state_nx    = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.capture) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/gdds_dp.sv]
module gdds_dp #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gdds_pkg::cmd_t                      cmd,
	output gdds_pkg::status_t                   status,
	input  logic [gdds_pkg::DAY_W-1:0]          load_day,
	input  logic [gdds_pkg::MONTH_W-1:0]        load_month,
	input  logic [gdds_pkg::YEAR_W-1:0]         load_year,
	input  logic signed [COUNT_WIDTH-1:0]       day_count,
	output logic [gdds_pkg::DAY_W-1:0]          day_out,
	output logic [gdds_pkg::MONTH_W-1:0]        month_out,
	output logic [gdds_pkg::YEAR_W-1:0]         year_out,
	output logic                                load_rejected,
	output logic                                range_clamped
);

	logic [gdds_pkg::DAY_W-1:0]   day_q;
	logic [gdds_pkg::MONTH_W-1:0] month_q;
	logic [gdds_pkg::YEAR_W-1:0]  year_q;
	logic [COUNT_WIDTH-1:0]       rem_q;
	logic                         neg_q;
	logic                         rejected_q;
	logic                         clamped_q;

	logic [gdds_pkg::DAY_W-1:0]   day_out_q;
	logic [gdds_pkg::MONTH_W-1:0] month_out_q;
	logic [gdds_pkg::YEAR_W-1:0]  year_out_q;
	logic                         rejected_out_q;
	logic                         clamped_out_q;

	logic                         cur_leap;
	logic [gdds_pkg::DAY_W-1:0]   cur_len;
	logic [gdds_pkg::MONTH_W-1:0] prev_month;
	logic [gdds_pkg::DAY_W-1:0]   prev_len;
	logic                         ld_leap;
	logic                         ld_valid;
	logic [COUNT_WIDTH-1:0]       magnitude;
	logic                         step_blocked;

	assign cur_leap   = gdds_pkg::is_leap(year_q);
	assign cur_len    = gdds_pkg::month_len(month_q, cur_leap);
	// only reached for months above January, so the year is unchanged
	assign prev_month = month_q - gdds_pkg::MONTH_FIRST;
	assign prev_len   = gdds_pkg::month_len(prev_month, cur_leap);

	assign ld_leap  = gdds_pkg::is_leap(load_year);
	assign ld_valid = (load_day >= gdds_pkg::DAY_FIRST)
		&& (load_month >= gdds_pkg::MONTH_FIRST) && (load_month <= gdds_pkg::MONTH_LAST)
		&& (load_year >= gdds_pkg::YEAR_MIN) && (load_year <= gdds_pkg::YEAR_MAX)
		&& (load_day <= gdds_pkg::month_len(load_month, ld_leap));

	// most negative count negates to itself: its magnitude is the sign bit alone
	assign magnitude = day_count[COUNT_WIDTH-1] ? (~day_count + COUNT_WIDTH'(1))
		: day_count;

	// next step would leave 1/1/1 .. 31/12/9999
	assign step_blocked = neg_q
		? ((day_q <= gdds_pkg::DAY_FIRST) && (month_q <= gdds_pkg::MONTH_FIRST)
			&& (year_q <= gdds_pkg::YEAR_MIN))
		: ((day_q >= cur_len) && (month_q >= gdds_pkg::MONTH_LAST)
			&& (year_q >= gdds_pkg::YEAR_MAX));

	assign status.rem_zero = (rem_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q      <= gdds_pkg::DAY_FIRST;
			month_q    <= gdds_pkg::MONTH_FIRST;
			year_q     <= gdds_pkg::YEAR_DEFAULT;
			rem_q      <= '0;
			neg_q      <= 1'b0;
			rejected_q <= 1'b0;
			clamped_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (ld_valid) begin
					day_q   <= load_day;
					month_q <= load_month;
					year_q  <= load_year;
				end else begin
					day_q   <= gdds_pkg::DAY_FIRST;
					month_q <= gdds_pkg::MONTH_FIRST;
					year_q  <= gdds_pkg::YEAR_DEFAULT;
				end
				rejected_q <= !ld_valid;
				clamped_q  <= 1'b0;
				rem_q      <= '0;
			end else if (cmd.start) begin
				rem_q      <= magnitude;
				neg_q      <= day_count[COUNT_WIDTH-1];
				rejected_q <= 1'b0;
				clamped_q  <= 1'b0;
			end else if (cmd.step) begin
				// a blocked step drops the rest of the count
				rem_q <= step_blocked ? '0 : rem_q - COUNT_WIDTH'(1);
				if (neg_q) begin
					if (day_q <= gdds_pkg::DAY_FIRST) begin
						if (month_q <= gdds_pkg::MONTH_FIRST) begin
							if (year_q <= gdds_pkg::YEAR_MIN) begin
								clamped_q <= 1'b1;
							end else begin
								year_q  <= year_q - gdds_pkg::YEAR_W'(1);
								month_q <= gdds_pkg::MONTH_LAST;
								day_q   <= gdds_pkg::DAY_W'(31);
							end
						end else begin
							month_q <= prev_month;
							day_q   <= prev_len;
						end
					end else begin
						day_q <= day_q - gdds_pkg::DAY_W'(1);
					end
				end else begin
					if (day_q >= cur_len) begin
						if (month_q >= gdds_pkg::MONTH_LAST) begin
							if (year_q >= gdds_pkg::YEAR_MAX) begin
								clamped_q <= 1'b1;
							end else begin
								year_q  <= year_q + gdds_pkg::YEAR_W'(1);
								month_q <= gdds_pkg::MONTH_FIRST;
								day_q   <= gdds_pkg::DAY_FIRST;
							end
						end else begin
							month_q <= month_q + gdds_pkg::MONTH_W'(1);
							day_q   <= gdds_pkg::DAY_FIRST;
						end
					end else begin
						day_q <= day_q + gdds_pkg::DAY_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			day_out_q      <= day_q;
			month_out_q    <= month_q;
			year_out_q     <= year_q;
			rejected_out_q <= rejected_q;
			clamped_out_q  <= clamped_q;
		end
	end

	assign day_out       = day_out_q;
	assign month_out     = month_out_q;
	assign year_out      = year_out_q;
	assign load_rejected = rejected_out_q;
	assign range_clamped = clamped_out_q;

endmodule
